FILE: src/mtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtf_pkg;

    localparam int LIST_DEPTH_DEF = 256;
    localparam int SYM_W          = 8;
    localparam int POS_W          = 8;
    localparam int LEN_W          = 9;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // register index decoded from paddr[2]
    localparam logic REG_LIST_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        MODE_ENCODE = 2'd0,
        MODE_DECODE = 2'd1,
        MODE_LOAD   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [SYM_W-1:0] symbol_in;
        logic [POS_W-1:0] position_in;
        logic             end_of_block;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0] position_out;
        logic [SYM_W-1:0] symbol_out;
        logic             error_flag;
        logic             end_of_block_out;
    } out_word_t;

    // list read address source
    typedef enum logic [1:0] {
        RD_CNT  = 2'd0,
        RD_POS  = 2'd1,
        RD_ZERO = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cnt_set1;
        logic    cnt_inc;
        logic    set_err;
        logic    take_match;
        logic    take_fetch;
        logic    shift_wr;
        logic    load_wr;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       in_range;
        logic       len_zero;
        logic       match;
        logic       at_last;
        logic       at_target;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: src/mtf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mtf_datapath import mtf_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    localparam int AW = $clog2(LIST_DEPTH),
    localparam int LW = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire in_word_t        s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output out_word_t            m_data,
    input  wire logic [LW-1:0]   eff_len,
    input  wire cmd_t            cmd,
    output sts_t                 sts
);

    // list storage, entries not yet written read as their own position
    logic [SYM_W-1:0]      order_mem_reg [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] vld_reg;

    logic [1:0]       mode_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [POS_W-1:0] pos_reg;
    logic             eob_reg;
    logic [POS_W-1:0] pos_out_reg;
    logic [SYM_W-1:0] sym_out_reg;
    logic             err_reg;

    logic [AW-1:0]    cnt_reg;
    logic [AW-1:0]    target_reg;
    logic [SYM_W-1:0] carry_reg;
    logic [SYM_W-1:0] mem_q_reg;
    logic             vld_q_reg;
    logic [AW-1:0]    rd_idx_reg;

    out_word_t        out_reg;
    logic             m_valid_reg;
    logic             m_valid_next;

    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [SYM_W-1:0] wr_data;
    logic             wr_en;
    logic [SYM_W-1:0] rdata;
    logic [AW-1:0]    last_idx;

    always_comb begin
        unique case (cmd.rd_sel)
            RD_CNT:  rd_addr = cnt_reg;
            RD_POS:  rd_addr = AW'(pos_reg);
            RD_ZERO: rd_addr = '0;
            default: rd_addr = '0;
        endcase
    end

    assign wr_en   = cmd.shift_wr | cmd.load_wr;
    assign wr_addr = cmd.shift_wr ? rd_idx_reg : AW'(pos_reg);
    assign wr_data = cmd.shift_wr ? carry_reg : sym_reg;

    assign rdata    = vld_q_reg ? mem_q_reg : SYM_W'(rd_idx_reg);
    assign last_idx = AW'(eff_len - LW'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            order_mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            mem_q_reg  <= order_mem_reg[rd_addr];
            vld_q_reg  <= vld_reg[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg    <= s_data.mode;
            sym_reg     <= s_data.symbol_in;
            pos_reg     <= s_data.position_in;
            eob_reg     <= s_data.end_of_block;
            pos_out_reg <= '0;
            sym_out_reg <= s_data.symbol_in;
            err_reg     <= 1'b0;
        end
        if (cmd.set_err) begin
            err_reg <= 1'b1;
        end
        priority if (cmd.capture) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_set1) begin
            cnt_reg <= AW'(1);
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + AW'(1);
        end
        if (cmd.take_match) begin
            target_reg  <= rd_idx_reg;
            carry_reg   <= sym_reg;
            pos_out_reg <= POS_W'(rd_idx_reg);
        end
        if (cmd.take_fetch) begin
            target_reg  <= AW'(pos_reg);
            carry_reg   <= rdata;
            sym_out_reg <= rdata;
        end
        if (cmd.shift_wr) begin
            carry_reg <= rdata;
        end
        if (cmd.out_load) begin
            out_reg.position_out     <= pos_out_reg;
            out_reg.symbol_out       <= sym_out_reg;
            out_reg.error_flag       <= err_reg;
            out_reg.end_of_block_out <= eob_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign sts.mode      = mode_reg;
    assign sts.in_range  = LEN_W'(pos_reg) < LEN_W'(eff_len);
    assign sts.len_zero  = (eff_len == '0);
    assign sts.match     = (rdata == sym_reg);
    assign sts.at_last   = (rd_idx_reg == last_idx);
    assign sts.at_target = (rd_idx_reg == target_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

FILE: src/mtf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mtf_ctrl import mtf_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SEARCH   = 6'b000100,
        S_FETCH    = 6'b001000,
        S_SHIFT    = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CNT;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // no word is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.mode)
                    MODE_ENCODE: begin
                        if (sts.len_zero) begin
                            cmd.set_err = 1'b1;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.rd_en   = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            state_next  = S_SEARCH;
                        end
                    end
                    MODE_DECODE: begin
                        if (!sts.in_range) begin
                            cmd.set_err = 1'b1;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                            state_next = S_FETCH;
                        end
                    end
                    MODE_LOAD: begin
                        if (!sts.in_range) begin
                            cmd.set_err = 1'b1;
                        end else begin
                            cmd.load_wr = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    default: begin
                        cmd.set_err = 1'b1;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_SEARCH: begin
                priority if (sts.match) begin
                    cmd.take_match = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel     = RD_ZERO;
                    cmd.cnt_set1   = 1'b1;
                    state_next     = S_SHIFT;
                end else if (sts.at_last) begin
                    cmd.set_err = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_FETCH: begin
                cmd.take_fetch = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = RD_ZERO;
                cmd.cnt_set1   = 1'b1;
                state_next     = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift_wr = 1'b1;
                if (sts.at_target) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/move_to_front_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// one word at a time; encode searches the list for the symbol, decode reads the entry at
// the position, and both then move that entry to the front; load writes one entry
// the walk over the symbol list (one read and one write port) takes one entry per cycle
// result appears on m_valid once the finish state has loaded it; a result may wait in the
// output register while the next word is taken
// reset (aresetn low, synchronous): list reads as identity at once, list_length 256
module move_to_front_codec import mtf_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input words
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    // result words
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int LW = $clog2(LIST_DEPTH + 1);

    logic [LEN_W-1:0] list_length_reg;
    logic [LW-1:0]    eff_len;
    logic             cfg_wr;
    cmd_t             cmd;
    sts_t             sts;

    // apb: zero wait states, register index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_length_reg <= LEN_W'(256);
        end else if (cfg_wr && (paddr[2] == REG_LIST_LENGTH)) begin
            list_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LIST_LENGTH) ? APB_DW'(list_length_reg) : '0;

    // length in use saturates at the list depth
    assign eff_len = (list_length_reg > LEN_W'(LIST_DEPTH)) ? LW'(LIST_DEPTH)
                                                            : LW'(list_length_reg);

    // sequencer: dispatch, search, fetch, shift, finish
    mtf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // symbol list memory, walk counters and output register
    mtf_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .eff_len (eff_len),
        .cmd     (cmd),
        .sts     (sts)
    );

    // a taken word blocks the input until its result is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a word was accepted");

    // a length write shows up in the register in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && (paddr[2] == REG_LIST_LENGTH)) |=>
            (list_length_reg == $past(pwdata[LEN_W-1:0])))
        else $error("list_length write lost");

    // a failed request never reports a position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_flag) |-> (m_data.position_out == '0))
        else $error("error result carries a nonzero position");

    // a new result is only loaded when the output side is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending result dropped");

endmodule
`default_nettype wire
